// ----- design/lbba_pkg.sv -----
package lbba_pkg;

  // Fixed field widths
  localparam int REQ_W      = 2;
  localparam int TIME_W     = 32;
  localparam int RATE_W     = 18;
  localparam int INTERVAL_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Default parameter values
  localparam int COUNT_WIDTH_DEF    = 16;
  localparam int LOSS_FRAC_BITS_DEF = 16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_SENT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACKED = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;
  localparam logic [REQ_W-1:0] REQ_INIT  = 2'd3;

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_UP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DOWN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 3'd4;

  // Register reset values
  localparam logic [RATE_W-1:0]     CEILING_RST   = 18'd64000;
  localparam logic [RATE_W-1:0]     FLOOR_RST     = 18'd16000;
  localparam logic [RATE_W-1:0]     STEP_UP_RST   = 18'd8000;
  localparam logic [RATE_W-1:0]     STEP_DOWN_RST = 18'd16000;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST  = 16'd1000;

  // Tiers between ceiling and floor
  localparam logic [RATE_W-1:0] TIER_MID_HI = 18'd48000;
  localparam logic [RATE_W-1:0] TIER_MID_LO = 18'd32000;

  // Smoothing weights in Q.16, alpha and one minus alpha
  localparam logic [15:0] ALPHA_Q16 = 16'd19661;
  localparam logic [15:0] BETA_Q16  = 16'd45875;

  // Loss thresholds in percent, and fewest sends for an evaluation
  localparam int LOSS_PCT_LO  = 2;
  localparam int LOSS_PCT_MID = 5;
  localparam int LOSS_PCT_HI  = 10;
  localparam int MIN_SENDS    = 10;

endpackage

// ----- design/lbba_in_if.sv -----
interface lbba_in_if;
  logic                         valid;
  logic                         ready;
  logic [lbba_pkg::REQ_W-1:0]  req_type;
  logic [lbba_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, output req_type, output now_ms, input ready);
  modport sink   (input valid, input req_type, input now_ms, output ready);
endinterface

// ----- design/lbba_out_if.sv -----
interface lbba_out_if;
  logic                         valid;
  logic                         ready;
  logic [lbba_pkg::RATE_W-1:0] bitrate;
  logic                         evaluated;

  modport source (output valid, output bitrate, output evaluated, input ready);
  modport sink   (input valid, input bitrate, input evaluated, output ready);
endinterface

// ----- design/lbba_cfg_if.sv -----
interface lbba_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lbba_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [lbba_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- design/loss_based_bitrate_adapter_core.sv -----
// Sent, acked, init and non-evaluating query requests go idle, exec, done; the result
// becomes valid once the output register is free. An evaluating query also runs the
// radix-2 divider at one quotient bit a cycle and two passes through one shared multiplier
// before the tier and step states; the divider is skipped when acks are at least sends.
// One request in flight: no new request is taken until the result leaves the done state.
// Synchronous active-low reset: registers to defaults, bitrate to the ceiling, rest to zero.
module loss_based_bitrate_adapter_core #(
  parameter int COUNT_WIDTH    = lbba_pkg::COUNT_WIDTH_DEF,
  parameter int LOSS_FRAC_BITS = lbba_pkg::LOSS_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lbba_in_if.sink    in_ch,
  lbba_out_if.source out_ch,
  lbba_cfg_if.sink   cfg_ch
);
  import lbba_pkg::*;

  localparam int CW      = COUNT_WIDTH;
  localparam int F       = LOSS_FRAC_BITS;
  localparam int CNT_W   = $clog2(F);
  localparam int PROD_W  = F + 17;
  localparam int ACC_W   = F + 18;
  localparam longint unsigned ONE_I = 64'd1 << F;
  localparam logic [F:0] LOSS_ONE = {1'b1, {F{1'b0}}};
  localparam logic [F:0] THR_LO   = (F+1)'((ONE_I * LOSS_PCT_LO + 50) / 100);
  localparam logic [F:0] THR_MID  = (F+1)'((ONE_I * LOSS_PCT_MID + 50) / 100);
  localparam logic [F:0] THR_HI   = (F+1)'((ONE_I * LOSS_PCT_HI + 50) / 100);
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_EXEC = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_MUL1 = 8'b0000_1000,
    S_MUL2 = 8'b0001_0000,
    S_TIER = 8'b0010_0000,
    S_STEP = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  // Configuration registers
  logic [RATE_W-1:0]     ceiling_r, floor_r, step_up_r, step_down_r;
  logic [INTERVAL_W-1:0] interval_r;

  // Control and adapter state
  state_t            state_r, state_nxt;
  logic [CW-1:0]     sent_r, sent_nxt, acked_r, acked_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [F:0]        sm_r, sm_nxt;
  logic [1:0]        up_r, up_nxt, down_r, down_nxt;
  logic              res_eval_r, res_eval_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Datapath registers
  logic [REQ_W-1:0]  req_r;
  logic [TIME_W-1:0] now_r;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [F-1:0]      q_r, q_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [F:0]        loss_r, loss_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [RATE_W-1:0] tier_r, tier_nxt;
  logic [RATE_W-1:0] out_bitrate_r;
  logic              out_eval_r;

  // Shared datapath pieces
  logic [TIME_W-1:0] elapsed;
  logic [CW:0]       rem_dbl, rem_sub;
  logic              div_ge;
  logic [F-1:0]      q_final;
  logic [15:0]       mul_a;
  logic [F:0]        mul_b;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc_sum;
  logic [RATE_W:0]   up_sum;
  logic [RATE_W-1:0] up_tier, up_next, dn_diff, dn_tier, dn_next;
  logic [1:0]        up_inc, down_inc;
  logic              in_acc, out_free;

  assign in_ch.ready    = (state_r == S_IDLE);
  assign cfg_ch.ready   = 1'b1;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.bitrate = out_bitrate_r;
  assign out_ch.evaluated = out_eval_r;

  assign in_acc   = in_ch.valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;

  // Elapsed time since last check, wrapping
  assign elapsed = now_r - last_r;

  // One restoring division step
  assign rem_dbl = {rem_r, 1'b0};
  assign div_ge  = (rem_dbl >= {1'b0, sent_r});
  assign rem_sub = rem_dbl - {1'b0, sent_r};
  assign q_final = {q_r[F-2:0], div_ge};

  // Shared multiplier: alpha times new loss, then one minus alpha times smoothed loss
  assign mul_a   = (state_r == S_MUL1) ? ALPHA_Q16 : BETA_Q16;
  assign mul_b   = (state_r == S_MUL1) ? loss_r : sm_r;
  assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign acc_sum = acc_r + {1'b0, prod};

  // Step up, limited by tier and ceiling
  assign up_sum  = {1'b0, rate_r} + {1'b0, step_up_r};
  assign up_tier = (up_sum > {1'b0, tier_r}) ? tier_r : up_sum[RATE_W-1:0];
  assign up_next = (up_tier > ceiling_r) ? ceiling_r : up_tier;

  // Step down without wrap, raised to tier then floor
  assign dn_diff = rate_r - step_down_r;
  assign dn_tier = ((rate_r < step_down_r) || (dn_diff < tier_r)) ? tier_r : dn_diff;
  assign dn_next = (dn_tier < floor_r) ? floor_r : dn_tier;

  assign up_inc   = (up_r == 2'd3) ? up_r : up_r + 2'd1;
  assign down_inc = (down_r == 2'd3) ? down_r : down_r + 2'd1;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    sent_nxt      = sent_r;
    acked_nxt     = acked_r;
    last_nxt      = last_r;
    rate_nxt      = rate_r;
    sm_nxt        = sm_r;
    up_nxt        = up_r;
    down_nxt      = down_r;
    res_eval_nxt  = res_eval_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    loss_nxt      = loss_r;
    acc_nxt       = acc_r;
    tier_nxt      = tier_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_eval_nxt = 1'b0;
        state_nxt    = S_DONE;
        case (req_r)
          REQ_SENT: begin
            if (sent_r != CNT_MAX) begin
              sent_nxt = sent_r + CW'(1);
            end
          end
          REQ_ACKED: begin
            if (acked_r != CNT_MAX) begin
              acked_nxt = acked_r + CW'(1);
            end
          end
          REQ_QUERY: begin
            if ({16'd0, interval_r} <= elapsed) begin
              if (sent_r < CW'(MIN_SENDS)) begin
                last_nxt = now_r;
              end else if (acked_r >= sent_r) begin
                // ratio clamps to one, so no loss
                loss_nxt  = '0;
                state_nxt = S_MUL1;
              end else begin
                rem_nxt   = acked_r;
                q_nxt     = '0;
                cnt_nxt   = '0;
                state_nxt = S_DIV;
              end
            end
          end
          default: begin
            sent_nxt  = '0;
            acked_nxt = '0;
            last_nxt  = now_r;
            rate_nxt  = ceiling_r;
            sm_nxt    = '0;
            up_nxt    = '0;
            down_nxt  = '0;
          end
        endcase
      end
      S_DIV: begin
        rem_nxt = div_ge ? rem_sub[CW-1:0] : rem_dbl[CW-1:0];
        q_nxt   = q_final;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(F - 1)) begin
          loss_nxt  = LOSS_ONE - {1'b0, q_final};
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        acc_nxt   = {1'b0, prod} + ROUND_HALF;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        sm_nxt    = acc_sum[F+16:16];
        state_nxt = S_TIER;
      end
      S_TIER: begin
        if (sm_r < THR_LO) begin
          tier_nxt = ceiling_r;
        end else if (sm_r < THR_MID) begin
          tier_nxt = TIER_MID_HI;
        end else if (sm_r < THR_HI) begin
          tier_nxt = TIER_MID_LO;
        end else begin
          tier_nxt = floor_r;
        end
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (tier_r > rate_r) begin
          down_nxt = '0;
          if (up_inc >= 2'd2) begin
            rate_nxt = up_next;
            up_nxt   = '0;
          end else begin
            up_nxt = up_inc;
          end
        end else if (tier_r < rate_r) begin
          up_nxt = '0;
          if (down_inc >= 2'd2) begin
            rate_nxt = dn_next;
            down_nxt = '0;
          end else begin
            down_nxt = down_inc;
          end
        end else begin
          up_nxt   = '0;
          down_nxt = '0;
        end
        sent_nxt     = '0;
        acked_nxt    = '0;
        last_nxt     = now_r;
        res_eval_nxt = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ceiling_r   <= CEILING_RST;
      floor_r     <= FLOOR_RST;
      step_up_r   <= STEP_UP_RST;
      step_down_r <= STEP_DOWN_RST;
      interval_r  <= INTERVAL_RST;
      sent_r      <= '0;
      acked_r     <= '0;
      last_r      <= '0;
      rate_r      <= CEILING_RST;
      sm_r        <= '0;
      up_r        <= '0;
      down_r      <= '0;
      res_eval_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sent_r      <= sent_nxt;
      acked_r     <= acked_nxt;
      last_r      <= last_nxt;
      rate_r      <= rate_nxt;
      sm_r        <= sm_nxt;
      up_r        <= up_nxt;
      down_r      <= down_nxt;
      res_eval_r  <= res_eval_nxt;
      out_valid_r <= out_valid_nxt;
      // take configuration writes; unknown indices drop
      if (cfg_ch.valid) begin
        case (cfg_ch.reg_index)
          CFG_CEILING:   ceiling_r   <= cfg_ch.wdata;
          CFG_FLOOR:     floor_r     <= cfg_ch.wdata;
          CFG_STEP_UP:   step_up_r   <= cfg_ch.wdata;
          CFG_STEP_DOWN: step_down_r <= cfg_ch.wdata;
          CFG_INTERVAL:  interval_r  <= cfg_ch.wdata[INTERVAL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_ch.req_type;
      now_r <= in_ch.now_ms;
    end
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
    loss_r <= loss_nxt;
    acc_r  <= acc_nxt;
    tier_r <= tier_nxt;
    if ((state_r == S_DONE) && out_free) begin
      out_bitrate_r <= rate_r;
      out_eval_r    <= res_eval_r;
    end
  end

  // Checks
  a_eval_only_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && res_eval_r |-> (req_r == REQ_QUERY))
    else $error("evaluation flagged for a request other than a query");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r <= CNT_W'(F - 1)) && (rem_r < sent_r))
    else $error("divider ran past its last step or remainder out of range");

  a_smooth_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL2) |=> (sm_r <= LOSS_ONE))
    else $error("smoothed loss above one");

  a_streaks: assert property (@(posedge clk) disable iff (!rst_n)
    (up_r < 2'd2) && (down_r < 2'd2) && !((up_r != 2'd0) && (down_r != 2'd0)))
    else $error("streak counters inconsistent");

endmodule

// ----- sim/tb_loss_based_bitrate_adapter_core.sv -----
`timescale 1ns / 1ps

module tb_loss_based_bitrate_adapter_core;
  import lbba_pkg::*;

  localparam longint LOSS_ONE       = longint'(1) << LOSS_FRAC_BITS_DEF;
  localparam int     NUM_SETTINGS   = 9;
  localparam int     SETTING_REQS   = 110;

  typedef struct {
    logic [RATE_W-1:0] bitrate;
    logic              evaluated;
  } bitrate_report_t;

  typedef struct {
    logic [RATE_W-1:0]     ceiling;
    logic [RATE_W-1:0]     floor;
    logic [RATE_W-1:0]     up;
    logic [RATE_W-1:0]     down;
    logic [INTERVAL_W-1:0] interval;
  } rate_limits_t;

  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [TIME_W-1:0] now;
    int                reps;
    logic              pinned;
    logic [RATE_W-1:0] bitrate;
    logic              evaluated;
  } probe_row_t;

  typedef enum int {LOSS_NONE, LOSS_LIGHT, LOSS_MODERATE, LOSS_HEAVY, ACK_SURPLUS} loss_mix_t;

  logic clk;
  logic rst_n;

  lbba_in_if  in_ch ();
  lbba_out_if out_ch ();
  lbba_cfg_if cfg_ch ();

  loss_based_bitrate_adapter_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Adapter state as the testbench tracks it
  logic [COUNT_WIDTH_DEF-1:0] sent_cnt;
  logic [COUNT_WIDTH_DEF-1:0] acked_cnt;
  logic [TIME_W-1:0]          last_check;
  logic [RATE_W-1:0]          cur_rate;
  logic [LOSS_FRAC_BITS_DEF:0] smooth_loss;
  logic [1:0]                 up_run;
  logic [1:0]                 down_run;
  logic [RATE_W-1:0]          ceiling_reg;
  logic [RATE_W-1:0]          floor_reg;
  logic [RATE_W-1:0]          step_up_reg;
  logic [RATE_W-1:0]          step_down_reg;
  logic [INTERVAL_W-1:0]      interval_reg;

  bitrate_report_t bitrate_due[$];

  bit        gaps_on;
  bit        stalls_on;
  loss_mix_t loss_mix;
  int        requests_done;
  int        evaluations;
  int        writes_done;
  int        mismatches;

  // Directed opening: hand values where they follow at once from the rules
  probe_row_t opening_rows[12] = '{
    '{REQ_QUERY, 32'd0,          1,  1'b1, 18'd64000, 1'b0},  // interval not yet elapsed
    '{REQ_QUERY, 32'd999,        1,  1'b1, 18'd64000, 1'b0},
    '{REQ_QUERY, 32'd1000,       1,  1'b1, 18'd64000, 1'b0},  // too few sends, timer restart
    '{REQ_SENT,  32'hFFFF_FFFF,  10, 1'b1, 18'd64000, 1'b0},
    '{REQ_ACKED, 32'hFFFF_FFFF,  1,  1'b1, 18'd64000, 1'b0},
    '{REQ_QUERY, 32'd1999,       1,  1'b1, 18'd64000, 1'b0},
    '{REQ_QUERY, 32'd2000,       1,  1'b1, 18'd64000, 1'b1},  // heavy loss, first vote down
    '{REQ_SENT,  32'd0,          10, 1'b0, 18'd0,     1'b0},
    '{REQ_QUERY, 32'd3000,       1,  1'b1, 18'd48000, 1'b1},  // second vote, one step down
    '{REQ_INIT,  32'hFFFF_FC18,  1,  1'b1, 18'd64000, 1'b0},
    '{REQ_QUERY, 32'hFFFF_FFFF,  1,  1'b1, 18'd64000, 1'b0},
    '{REQ_QUERY, 32'd0,          1,  1'b1, 18'd64000, 1'b0}   // elapsed time wraps
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint loss_threshold(input int pct);
    return (LOSS_ONE * pct + 50) / 100;
  endfunction

  task automatic restart_model(input logic [TIME_W-1:0] now);
    sent_cnt    = '0;
    acked_cnt   = '0;
    last_check  = now;
    cur_rate    = ceiling_reg;
    smooth_loss = '0;
    up_run      = '0;
    down_run    = '0;
  endtask

  // Loss ratio, smoothing, tier choice and the two-vote step towards the tier
  task automatic evaluate_loss();
    longint sends, acks, ratio, loss, smooth_v, tier, next_rate;
    longint ceil_v, floor_v, rate_v;
    sends    = sent_cnt;
    acks     = acked_cnt;
    smooth_v = smooth_loss;
    ceil_v   = ceiling_reg;
    floor_v  = floor_reg;
    rate_v   = cur_rate;
    ratio = (acks << LOSS_FRAC_BITS_DEF) / sends;
    if (ratio > LOSS_ONE) ratio = LOSS_ONE;
    loss = LOSS_ONE - ratio;
    smooth_v = (ALPHA_Q16 * loss + BETA_Q16 * smooth_v + 32768) >> 16;
    smooth_loss = smooth_v[LOSS_FRAC_BITS_DEF:0];

    if (smooth_v < loss_threshold(LOSS_PCT_LO)) begin
      tier = ceil_v;
    end else if (smooth_v < loss_threshold(LOSS_PCT_MID)) begin
      tier = TIER_MID_HI;
    end else if (smooth_v < loss_threshold(LOSS_PCT_HI)) begin
      tier = TIER_MID_LO;
    end else begin
      tier = floor_v;
    end

    if (tier > rate_v) begin
      if (up_run != 2'd3) up_run++;
      down_run = '0;
      if (up_run >= 2'd2) begin
        next_rate = rate_v + step_up_reg;
        if (next_rate > tier) next_rate = tier;
        if (next_rate > ceil_v) next_rate = ceil_v;
        cur_rate = next_rate[RATE_W-1:0];
        up_run   = '0;
      end
    end else if (tier < rate_v) begin
      if (down_run != 2'd3) down_run++;
      up_run = '0;
      if (down_run >= 2'd2) begin
        next_rate = rate_v - step_down_reg;
        if (next_rate < tier) next_rate = tier;
        if (next_rate < floor_v) next_rate = floor_v;
        cur_rate = next_rate[RATE_W-1:0];
        down_run = '0;
      end
    end else begin
      up_run   = '0;
      down_run = '0;
    end
  endtask

  task automatic predict_bitrate(input logic [REQ_W-1:0] req, input logic [TIME_W-1:0] now,
                                 output logic [RATE_W-1:0] rate_o, output logic eval_o);
    logic [TIME_W-1:0] elapsed;
    eval_o = 1'b0;
    case (req)
      REQ_SENT: begin
        if (~&sent_cnt) sent_cnt++;
      end
      REQ_ACKED: begin
        if (~&acked_cnt) acked_cnt++;
      end
      REQ_QUERY: begin
        elapsed = now - last_check;
        if (elapsed >= TIME_W'(interval_reg)) begin
          if (sent_cnt >= MIN_SENDS) begin
            evaluate_loss();
            sent_cnt  = '0;
            acked_cnt = '0;
            eval_o    = 1'b1;
            evaluations++;
          end
          last_check = now;
        end
      end
      REQ_INIT: begin
        restart_model(now);
      end
      default: ;
    endcase
    rate_o = cur_rate;
  endtask

  // Present one request after a random gap, hold it until taken, then log its result
  task automatic issue(input logic [REQ_W-1:0] req, input logic [TIME_W-1:0] now,
                       input logic pinned = 1'b0, input logic [RATE_W-1:0] pin_rate = '0,
                       input logic pin_eval = 1'b0);
    int              gap;
    bitrate_report_t due;
    gap = gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.now_ms   <= now;
    do @(posedge clk); while (!in_ch.ready);
    predict_bitrate(req, now, due.bitrate, due.evaluated);
    if (pinned) begin
      due.bitrate   = pin_rate;
      due.evaluated = pin_eval;
    end
    bitrate_due.push_back(due);
    requests_done++;
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (bitrate_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all five registers back to back, plus one write to an unused index
  task automatic program_registers(input rate_limits_t lim);
    logic [CFG_IDX_W-1:0]  idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    idx = '{CFG_CEILING, CFG_FLOOR, CFG_STEP_UP, CFG_STEP_DOWN, CFG_INTERVAL,
            CFG_INTERVAL + CFG_IDX_W'($urandom_range(1, 3))};
    val = '{lim.ceiling, lim.floor, lim.up, lim.down,
            {2'($urandom_range(0, 3)), lim.interval}, CFG_DATA_W'($urandom)};
    for (int i = 0; i < 6; i++) begin
      cfg_ch.valid     <= 1'b1;
      cfg_ch.reg_index <= idx[i];
      cfg_ch.wdata     <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
      case (idx[i])
        CFG_CEILING:   ceiling_reg   = val[i];
        CFG_FLOOR:     floor_reg     = val[i];
        CFG_STEP_UP:   step_up_reg   = val[i];
        CFG_STEP_DOWN: step_down_reg = val[i];
        CFG_INTERVAL:  interval_reg  = val[i][INTERVAL_W-1:0];
        default: ;
      endcase
      writes_done++;
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // One burst of sends and acks at a chosen loss level, with some noise, closed by a query
  task automatic traffic_round();
    int                sends;
    int                acks;
    int                pick;
    logic [TIME_W-1:0] t;
    if ($urandom_range(0, 9) < 3) loss_mix = loss_mix_t'($urandom_range(0, 4));
    gaps_on   = ($urandom_range(0, 3) != 0);
    stalls_on = ($urandom_range(0, 3) != 0);
    sends = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9) : $urandom_range(10, 40);
    case (loss_mix)
      LOSS_NONE:     acks = sends;
      LOSS_LIGHT:    acks = sends * (100 - $urandom_range(1, 4)) / 100;
      LOSS_MODERATE: acks = sends * (100 - $urandom_range(4, 9)) / 100;
      LOSS_HEAVY:    acks = sends * (100 - $urandom_range(10, 100)) / 100;
      default:       acks = sends + $urandom_range(1, 5);
    endcase

    while (sends + acks > 0) begin
      pick = $urandom_range(0, 99);
      if (pick == 0) begin
        issue(REQ_W'($urandom_range(0, 3)), $urandom);
      end else if (pick < 3) begin
        issue(REQ_QUERY, last_check + TIME_W'($urandom_range(0, 2000)));
      end else if (acks > 0 && (sends == 0 || pick < 45)) begin
        issue(REQ_ACKED, $urandom);
        acks--;
      end else begin
        issue(REQ_SENT, $urandom);
        sends--;
      end
    end

    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      t = last_check + TIME_W'(interval_reg) + TIME_W'($urandom_range(0, 40));
    end else if (pick < 17 && interval_reg > 1) begin
      t = last_check + TIME_W'($urandom_range(0, interval_reg - 1));
    end else begin
      t = $urandom;
    end
    issue(REQ_QUERY, t);
  endtask

  // Result side: random stalls, compare each accepted result with the oldest prediction
  initial begin
    int              stall;
    bitrate_report_t due;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = stalls_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (bitrate_due.size() == 0) begin
        mismatches++;
        $error("result with no request outstanding: bitrate %0d evaluated %0b",
               out_ch.bitrate, out_ch.evaluated);
      end else begin
        due = bitrate_due.pop_front();
        if (out_ch.bitrate !== due.bitrate) begin
          mismatches++;
          $error("bitrate: expected %0d, got %0d", due.bitrate, out_ch.bitrate);
        end
        if (out_ch.evaluated !== due.evaluated) begin
          mismatches++;
          $error("evaluated: expected %0b, got %0b", due.evaluated, out_ch.evaluated);
        end
      end
    end
  end

  // Request side and run sequence
  initial begin
    rate_limits_t lim;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_SENT;
    in_ch.now_ms     <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= CFG_CEILING;
    cfg_ch.wdata     <= '0;
    gaps_on          = 1'b1;
    stalls_on        = 1'b1;
    loss_mix         = LOSS_NONE;
    requests_done    = 0;
    evaluations      = 0;
    writes_done      = 0;
    mismatches       = 0;
    ceiling_reg      = CEILING_RST;
    floor_reg        = FLOOR_RST;
    step_up_reg      = STEP_UP_RST;
    step_down_reg    = STEP_DOWN_RST;
    interval_reg     = INTERVAL_RST;
    restart_model('0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening
    foreach (opening_rows[r]) begin
      repeat (opening_rows[r].reps)
        issue(opening_rows[r].req, opening_rows[r].now, opening_rows[r].pinned,
              opening_rows[r].bitrate, opening_rows[r].evaluated);
    end
    settle();

    // Random traffic over a sweep of register settings
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s)
        0: lim = '{CEILING_RST, FLOOR_RST, STEP_UP_RST, STEP_DOWN_RST, INTERVAL_RST};
        1: lim = '{18'h3FFFF, 18'd0, 18'h3FFFF, 18'h3FFFF, 16'd0};
        2: lim = '{18'd0, 18'd0, 18'd0, 18'd0, 16'd1};
        3: lim = '{18'd24000, 18'd56000, 18'd5000, 18'd7000, 16'hFFFF};
        4: lim = '{18'h3FFFF, 18'h3FFFF, 18'd1, 18'd1, 16'd10};
        default: begin
          lim.ceiling  = RATE_W'($urandom_range(30000, 100000));
          lim.floor    = RATE_W'($urandom_range(0, 40000));
          lim.up       = RATE_W'($urandom_range(0, 40000));
          lim.down     = RATE_W'($urandom_range(0, 40000));
          lim.interval = INTERVAL_W'($urandom_range(0, 3000));
          if ($urandom_range(0, 3) == 0) begin
            lim.ceiling = RATE_W'($urandom);
            lim.floor   = RATE_W'($urandom);
          end
        end
      endcase
      program_registers(lim);
      if ($urandom_range(0, 1) == 1) issue(REQ_INIT, $urandom);
      begin
        int start_reqs;
        start_reqs = requests_done;
        while (requests_done - start_reqs < SETTING_REQS) traffic_round();
      end
      settle();
    end

    repeat (30) @(posedge clk);
    $display("Covered %0d requests of mixed loss levels, wrapped timestamps and stalls,",
             requests_done);
    $display("%0d loss evaluations, %0d register writes over %0d settings, %0d mismatches",
             evaluations, writes_done, NUM_SETTINGS, mismatches);
    if (mismatches == 0 && bitrate_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
